// ===== hdl/tournament_branch_predictor_core_macros.svh =====
// Assertion macros for the tournament branch predictor checker.
// No dependencies; included by the files that carry assertions.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_CORE_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_CORE_MACROS_SVH

// Same-cycle implication, gated by a disable condition.
`define TBP_ASSERT_IMP(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("tbp: property failed");

// Next-cycle implication, gated by a disable condition.
`define TBP_ASSERT_NXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("tbp: property failed");

`endif

// ===== hdl/tbp_pkg.sv =====
// Shared constants, types and counter helpers of the tournament branch predictor.
// No dependencies; used by every other file of the block but the macros header.
package tbp_pkg;

  localparam int GLOBAL_HISTORY_BITS_DEF = 9;
  localparam int LOCAL_HISTORY_BITS_DEF  = 10;
  localparam int ADDRESS_INDEX_BITS_DEF  = 10;

  localparam int ADDRESS_WIDTH = 32;

  // Power of two, so pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CTR_RESET = 2'd1;
  localparam logic [1:0] CTR_MAX   = 2'd3;
  localparam logic [1:0] CTR_MIN   = 2'd0;

  typedef struct packed {
    logic valid;
    logic taken;
  } head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

  function automatic logic [1:0] sat_update(input logic [1:0] ctr, input logic up);
    logic [1:0] res;
    res = ctr;
    if (up) begin
      if (ctr != CTR_MAX) res = ctr + 2'd1;
    end else begin
      if (ctr != CTR_MIN) res = ctr - 2'd1;
    end
    return res;
  endfunction

  function automatic logic ctr_taken(input logic [1:0] ctr);
    return ctr[1];
  endfunction

endpackage

// ===== hdl/tbp_if.sv =====
// Request and result channels of the tournament branch predictor.
// Depends on tbp_pkg for the address width.
interface tbp_in_if;
  logic                              valid;
  logic                              ready;
  logic [tbp_pkg::ADDRESS_WIDTH-1:0] branch_address;
  logic                              taken;

  modport source (output valid, output branch_address, output taken, input ready);
  modport sink   (input valid, input branch_address, input taken, output ready);
endinterface

interface tbp_out_if;
  logic valid;
  logic ready;
  logic prediction;
  logic chose_local;

  modport source (output valid, output prediction, output chose_local, input ready);
  modport sink   (input valid, input prediction, input chose_local, output ready);
endinterface

// ===== hdl/tbp_front.sv =====
// Front end: takes branch requests, keeps the address index bits and the outcome,
// and holds them in a short queue for the back end. Depends on tbp_pkg and tbp_if.
module tbp_front #(
  parameter int ADDRESS_INDEX_BITS = tbp_pkg::ADDRESS_INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  tbp_in_if.sink                        branch,
  input  tbp_pkg::back_ctl_t            ctl,
  output tbp_pkg::head_t                head,
  output logic [ADDRESS_INDEX_BITS-1:0] head_addr
);
  import tbp_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [ADDRESS_INDEX_BITS-1:0] q_addr  [QUEUE_DEPTH];
  logic                          q_taken [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]           wr_ptr;
  logic [PTR_BITS-1:0]           rd_ptr;
  logic [CNT_BITS-1:0]           count;
  logic                          push;
  logic                          pop;

  assign branch.ready = (count != CNT_BITS'(QUEUE_DEPTH)) && !ctl.clearing;
  assign push         = branch.valid && branch.ready;
  assign pop          = ctl.pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.taken = q_taken[rd_ptr];
  assign head_addr  = q_addr[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_addr[wr_ptr]  <= branch.branch_address[ADDRESS_INDEX_BITS-1:0];
      q_taken[wr_ptr] <= branch.taken;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hdl/tbp_back.sv =====
// Back end: clears the tables after reset, then reads, predicts and trains one
// branch at a time and registers the result. Depends on tbp_pkg and tbp_if.
module tbp_back #(
  parameter int GLOBAL_HISTORY_BITS = tbp_pkg::GLOBAL_HISTORY_BITS_DEF,
  parameter int LOCAL_HISTORY_BITS  = tbp_pkg::LOCAL_HISTORY_BITS_DEF,
  parameter int ADDRESS_INDEX_BITS  = tbp_pkg::ADDRESS_INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tbp_pkg::head_t                head,
  input  logic [ADDRESS_INDEX_BITS-1:0] head_addr,
  output tbp_pkg::back_ctl_t            ctl,
  tbp_out_if.source                     result
);
  import tbp_pkg::*;

  localparam int GHB = GLOBAL_HISTORY_BITS;
  localparam int LHB = LOCAL_HISTORY_BITS;
  localparam int AIB = ADDRESS_INDEX_BITS;
  localparam int G_DEPTH = 1 << GHB;
  localparam int L_DEPTH = 1 << LHB;
  localparam int A_DEPTH = 1 << AIB;
  localparam int CLR_BITS = (GHB > LHB) ? ((GHB > AIB) ? GHB : AIB)
                                        : ((LHB > AIB) ? LHB : AIB);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LREAD,
    S_UPDATE
  } state_t;

  state_t              state;
  logic [CLR_BITS-1:0] clr_idx;
  logic [GHB-1:0]      ghist;
  logic [AIB-1:0]      addr_q;
  logic                taken_q;
  logic                res_valid;
  logic                res_pred;
  logic                res_local;

  logic [1:0]     gctr_mem [G_DEPTH];
  logic [1:0]     chs_mem  [G_DEPTH];
  logic [1:0]     lctr_mem [L_DEPTH];
  logic [LHB-1:0] lhist_mem [A_DEPTH];

  logic [1:0]     gctr_rd;
  logic [1:0]     chs_rd;
  logic [1:0]     lctr_rd;
  logic [LHB-1:0] lhist_rd;

  logic           clearing;
  logic           wr_en;
  logic           start;
  logic           g_pred;
  logic           l_pred;
  logic           use_local;
  logic [GHB-1:0] g_waddr;
  logic [LHB-1:0] l_waddr;
  logic [AIB-1:0] a_waddr;
  logic [1:0]     gctr_wdata;
  logic [1:0]     chs_wdata;
  logic [1:0]     lctr_wdata;
  logic [LHB-1:0] lhist_wdata;
  logic [1:0]     chs_next;
  logic [GHB-1:0] ghist_next;

  assign clearing = (state == S_CLEAR);
  assign wr_en    = clearing || (state == S_UPDATE);
  assign start    = (state == S_IDLE) && head.valid && (!res_valid || result.ready);

  assign ctl.pop      = start;
  assign ctl.clearing = clearing;

  assign g_pred    = ctr_taken(gctr_rd);
  assign l_pred    = ctr_taken(lctr_rd);
  assign use_local = ctr_taken(chs_rd);

  always_comb begin
    chs_next = chs_rd;
    if ((g_pred == taken_q) && (l_pred != taken_q)) begin
      chs_next = sat_update(chs_rd, 1'b0);
    end else if ((g_pred != taken_q) && (l_pred == taken_q)) begin
      chs_next = sat_update(chs_rd, 1'b1);
    end
  end

  assign ghist_next = (ghist << 1) | GHB'(taken_q);

  assign g_waddr     = clearing ? clr_idx[GHB-1:0] : ghist;
  assign l_waddr     = clearing ? clr_idx[LHB-1:0] : lhist_rd;
  assign a_waddr     = clearing ? clr_idx[AIB-1:0] : addr_q;
  assign gctr_wdata  = clearing ? CTR_RESET : sat_update(gctr_rd, taken_q);
  assign chs_wdata   = clearing ? CTR_RESET : chs_next;
  assign lctr_wdata  = clearing ? CTR_RESET : sat_update(lctr_rd, taken_q);
  assign lhist_wdata = clearing ? '0 : ((lhist_rd << 1) | LHB'(taken_q));

  always_ff @(posedge clk) begin
    if (wr_en) gctr_mem[g_waddr] <= gctr_wdata;
    if (start) gctr_rd <= gctr_mem[ghist];
  end

  always_ff @(posedge clk) begin
    if (wr_en) chs_mem[g_waddr] <= chs_wdata;
    if (start) chs_rd <= chs_mem[ghist];
  end

  always_ff @(posedge clk) begin
    if (wr_en) lhist_mem[a_waddr] <= lhist_wdata;
    if (start) lhist_rd <= lhist_mem[head_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) lctr_mem[l_waddr] <= lctr_wdata;
    if (state == S_LREAD) lctr_rd <= lctr_mem[lhist_rd];
  end

  assign result.valid       = res_valid;
  assign result.prediction  = res_pred;
  assign result.chose_local = res_local;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      ghist     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && result.ready) res_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            addr_q  <= head_addr;
            taken_q <= head.taken;
            state   <= S_LREAD;
          end
        end
        S_LREAD: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          ghist     <= ghist_next;
          res_valid <= 1'b1;
          res_pred  <= use_local ? l_pred : g_pred;
          res_local <= use_local;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

// ===== hdl/tournament_branch_predictor_core.sv =====
// Tournament branch predictor: each request is one resolved conditional branch
// (address and outcome); each result is the prediction made before training and
// whether the chooser picked the local side. The back end handles a branch in
// steps: it reads the global counter, chooser and local history tables, then reads
// the local counter through the history just fetched, and last it writes all four
// tables back and registers the result. It takes no new branch from the two-entry
// input queue until it is through with the last one and its result register is
// free or being read. After reset a clearing pass steps an index through all
// 2^max(GLOBAL_HISTORY_BITS, LOCAL_HISTORY_BITS, ADDRESS_INDEX_BITS) values and
// writes the reset values; no request is taken during it.
module tournament_branch_predictor_core #(
  parameter int GLOBAL_HISTORY_BITS = tbp_pkg::GLOBAL_HISTORY_BITS_DEF,
  parameter int LOCAL_HISTORY_BITS  = tbp_pkg::LOCAL_HISTORY_BITS_DEF,
  parameter int ADDRESS_INDEX_BITS  = tbp_pkg::ADDRESS_INDEX_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  tbp_in_if.sink    branch,
  tbp_out_if.source result
);
  import tbp_pkg::*;

  head_t                         head;
  logic [ADDRESS_INDEX_BITS-1:0] head_addr;
  back_ctl_t                     ctl;

  tbp_front #(
    .ADDRESS_INDEX_BITS (ADDRESS_INDEX_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .branch    (branch),
    .ctl       (ctl),
    .head      (head),
    .head_addr (head_addr)
  );

  tbp_back #(
    .GLOBAL_HISTORY_BITS (GLOBAL_HISTORY_BITS),
    .LOCAL_HISTORY_BITS  (LOCAL_HISTORY_BITS),
    .ADDRESS_INDEX_BITS  (ADDRESS_INDEX_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .head_addr (head_addr),
    .ctl       (ctl),
    .result    (result)
  );

endmodule

// ===== hdl/tbp_checker.sv =====
// Port-level checks of the tournament branch predictor, bound to its top level.
// Depends on tbp_pkg and tournament_branch_predictor_core_macros.svh.
`include "tournament_branch_predictor_core_macros.svh"

module tbp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic prediction,
  input logic chose_local
);
  import tbp_pkg::*;

  // Queue entries, one in the back end, one in the result register.
  localparam int MAX_OUTSTANDING = QUEUE_DEPTH + 2;
  localparam int OUT_BITS = $clog2(MAX_OUTSTANDING + 2);

  logic [OUT_BITS-1:0] outstanding;
  logic                in_acc;
  logic                out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   outstanding <= outstanding + 1'b1;
        2'b01:   outstanding <= outstanding - 1'b1;
        default: outstanding <= outstanding;
      endcase
    end
  end

  `TBP_ASSERT_NXT(a_clear_after_reset, clk, 1'b0, rst, !in_ready)
  `TBP_ASSERT_IMP(a_result_has_request, clk, rst, out_valid, outstanding != '0)
  `TBP_ASSERT_IMP(a_outstanding_bound, clk, rst, 1'b1, outstanding <= OUT_BITS'(MAX_OUTSTANDING))
  `TBP_ASSERT_NXT(a_result_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(prediction) && $stable(chose_local))

endmodule

bind tournament_branch_predictor_core tbp_checker u_tbp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (branch.valid),
  .in_ready    (branch.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .prediction  (result.prediction),
  .chose_local (result.chose_local)
);
